FILE: src/dtsl_pkg.sv
// ----------------------------------------------------------------------------
// dtsl_pkg
// Shared types and constants for the serial tuning-word loader.
// ----------------------------------------------------------------------------
package dtsl_pkg;

	localparam int unsigned TW_W        = 32;
	localparam int unsigned CTL_W       = 8;
	localparam int unsigned DIV_STEPS   = 32;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned IDX_W       = 6;

	localparam logic [31:0] REF_CLK_RESET = 32'd125000000;
	localparam logic [7:0]  PD_CONTROL    = 8'h20;

	// action index of the update pulse that closes a frame
	localparam logic [IDX_W-1:0] FRAME_UPD_POS = 6'd40;
	localparam logic [IDX_W-1:0] FRAME_CTL_POS = 6'd32;
	localparam logic [IDX_W-1:0] PWDN_PREFIX   = 6'd2;
	localparam logic [IDX_W-1:0] INIT_WCLK_POS = 6'd1;
	localparam logic [IDX_W-1:0] INIT_UPD_POS  = 6'd2;

	typedef enum logic [1:0] {
		OP_SETF  = 2'd0,
		OP_PWDN  = 2'd1,
		OP_INIT  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t           kind;
		logic [TW_W-1:0]   tw;
		logic [CTL_W-1:0]  ctl;
	} frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} push_t;

	// low five phase bits reversed, upper three pass through
	function automatic logic [CTL_W-1:0] reverse_phase(input logic [CTL_W-1:0] c);
		return {c[7:5], c[0], c[1], c[2], c[3], c[4]};
	endfunction

endpackage

FILE: src/dds_tuning_word_serial_loader_core.sv
// ----------------------------------------------------------------------------
// dds_tuning_word_serial_loader_core
// Turns frequency, power-down and init requests into serial pin actions.
// ----------------------------------------------------------------------------
// Set-frequency requests below the reference clock pass through the divider before
// they are queued; saturated set frequency, power down and init skip it.
// Throughput: one action per cycle from the serializer while the sink does not stall;
// division overlaps the runs ahead and only idles behind short runs.
// Reset: async, active low; reference clock returns to 125 MHz, queue empties.
module dds_tuning_word_serial_loader_core #(
	parameter int unsigned QUEUE_DEPTH = dtsl_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] frequency_hz,
	input  logic [7:0]  control_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        data_bit,
	output logic        word_clock_pulse,
	output logic        update_pulse,
	output logic        reset_pulse,
	output logic        last
);

	dtsl_pkg::push_t   push;
	dtsl_pkg::frame_t  head;
	logic              q_full;
	logic              head_valid;
	logic              pop;

	dtsl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.frequency_hz (frequency_hz),
		.control_word (control_word),
		.q_full       (q_full),
		.push         (push)
	);

	dtsl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	dtsl_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_valid       (head_valid),
		.head             (head),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.data_bit         (data_bit),
		.word_clock_pulse (word_clock_pulse),
		.update_pulse     (update_pulse),
		.reset_pulse      (reset_pulse),
		.last             (last)
	);

endmodule

FILE: src/dtsl_front.sv
// ----------------------------------------------------------------------------
// dtsl_front
// Takes requests, classifies them and computes the tuning word with a
// radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtsl_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [31:0]                cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 opcode,
	input  logic [31:0]                frequency_hz,
	input  logic [7:0]                 control_word,
	input  logic                       q_full,
	output dtsl_pkg::push_t            push
);

	logic [31:0]                   ref_clk_q;
	logic                          busy_q;
	logic                          hold_q;
	logic [4:0]                    cnt_q;
	logic [31:0]                   rem_q;
	dtsl_pkg::frame_t              frame_q;

	logic                          accept;
	logic                          do_push;
	logic                          saturate;
	logic [32:0]                   trial;
	logic [32:0]                   diff;
	logic                          qbit;
	logic [31:0]                   rem_nxt;

	assign do_push  = hold_q && !q_full;
	assign in_stall = busy_q || (hold_q && !do_push);
	assign accept   = in_valid && !in_stall;

	// quotient of (f << 32) / clk only fits in 32 bits when f < clk
	assign saturate = (ref_clk_q == 32'd0) || (frequency_hz >= ref_clk_q);

	assign trial   = {rem_q, 1'b0};
	assign diff    = trial - {1'b0, ref_clk_q};
	assign qbit    = (trial >= {1'b0, ref_clk_q});
	assign rem_nxt = qbit ? diff[31:0] : trial[31:0];

	assign push.valid = do_push;
	assign push.frame = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clk_q <= dtsl_pkg::REF_CLK_RESET;
			busy_q    <= 1'b0;
			hold_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				ref_clk_q <= cfg_wr_data;
			end
			if (do_push) begin
				hold_q <= 1'b0;
			end
			if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(dtsl_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					hold_q <= 1'b1;
				end
			end
			if (accept) begin
				unique case (dtsl_pkg::opcode_t'(opcode))
					dtsl_pkg::OP_SETF: begin
						if (saturate) begin
							hold_q <= 1'b1;
						end else begin
							busy_q <= 1'b1;
							cnt_q  <= '0;
						end
					end
					dtsl_pkg::OP_PWDN,
					dtsl_pkg::OP_INIT: begin
						hold_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q      <= rem_nxt;
			frame_q.tw <= {frame_q.tw[30:0], qbit};
		end
		if (accept) begin
			frame_q.kind <= dtsl_pkg::opcode_t'(opcode);
			rem_q        <= frequency_hz;
			unique case (dtsl_pkg::opcode_t'(opcode))
				dtsl_pkg::OP_SETF: begin
					frame_q.ctl <= dtsl_pkg::reverse_phase(control_word);
					frame_q.tw  <= saturate ? 32'hFFFF_FFFF : 32'd0;
				end
				dtsl_pkg::OP_PWDN: begin
					frame_q.ctl <= dtsl_pkg::reverse_phase(dtsl_pkg::PD_CONTROL);
					frame_q.tw  <= 32'd0;
				end
				default: begin
					frame_q.ctl <= '0;
					frame_q.tw  <= 32'd0;
				end
			endcase
		end
	end

endmodule

FILE: src/dtsl_queue.sv
// ----------------------------------------------------------------------------
// dtsl_queue
// Small frame queue between the divider front and the serializer.
// ----------------------------------------------------------------------------
module dtsl_queue #(
	parameter int unsigned DEPTH = dtsl_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dtsl_pkg::push_t   push,
	output logic              full,
	output logic              head_valid,
	output dtsl_pkg::frame_t  head,
	input  logic              pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	dtsl_pkg::frame_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               wr;
	logic               rd;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign wr         = push.valid && !full;
	assign rd         = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= push.frame;
		end
	end

endmodule

FILE: src/dtsl_back.sv
// ----------------------------------------------------------------------------
// dtsl_back
// Serializer: walks one queued frame, one pin action per cycle unless the output
// stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module dtsl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  dtsl_pkg::frame_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              data_bit,
	output logic              word_clock_pulse,
	output logic              update_pulse,
	output logic              reset_pulse,
	output logic              last
);

	logic [dtsl_pkg::IDX_W-1:0]  idx_q;
	logic                        out_valid_q;
	logic                        d_q, wc_q, up_q, rs_q, last_q;

	logic                        load;
	logic [dtsl_pkg::IDX_W-1:0]  pos;
	logic                        d_n, wc_n, up_n, rs_n, last_n;

	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop  = load && last_n;

	always_comb begin
		d_n    = 1'b0;
		wc_n   = 1'b0;
		up_n   = 1'b0;
		rs_n   = 1'b0;
		last_n = 1'b0;
		pos    = (head.kind == dtsl_pkg::OP_PWDN) ? idx_q - dtsl_pkg::PWDN_PREFIX : idx_q;
		if (head.kind == dtsl_pkg::OP_INIT) begin
			rs_n   = (idx_q == '0);
			wc_n   = (idx_q == dtsl_pkg::INIT_WCLK_POS);
			up_n   = (idx_q == dtsl_pkg::INIT_UPD_POS);
			last_n = up_n;
		end else if (head.kind == dtsl_pkg::OP_PWDN && idx_q < dtsl_pkg::PWDN_PREFIX) begin
			// serial-mode entry
			wc_n = (idx_q == '0);
			up_n = (idx_q != '0);
		end else if (pos < dtsl_pkg::FRAME_CTL_POS) begin
			d_n  = head.tw[pos[4:0]];
			wc_n = 1'b1;
		end else if (pos < dtsl_pkg::FRAME_UPD_POS) begin
			// control byte MSB first
			d_n  = head.ctl[~pos[2:0]];
			wc_n = 1'b1;
		end else begin
			up_n   = 1'b1;
			last_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= head_valid;
			end
			if (load) begin
				idx_q <= last_n ? '0 : idx_q + dtsl_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			d_q    <= d_n;
			wc_q   <= wc_n;
			up_q   <= up_n;
			rs_q   <= rs_n;
			last_q <= last_n;
		end
	end

	assign out_valid        = out_valid_q;
	assign data_bit         = d_q;
	assign word_clock_pulse = wc_q;
	assign update_pulse     = up_q;
	assign reset_pulse      = rs_q;
	assign last             = last_q;

endmodule

FILE: verif/dtsl_action_checker.sv
// ----------------------------------------------------------------------------
// dtsl_action_checker
// Watches the request and pin-action channels of the tuning-word loader,
// builds the expected action run for every accepted request and compares
// each accepted action with the oldest one still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtsl_action_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] frequency_hz,
	input  logic [7:0]  control_word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        data_bit,
	input  logic        word_clock_pulse,
	input  logic        update_pulse,
	input  logic        reset_pulse,
	input  logic        last,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic data_bit;
		logic word_clock_pulse;
		logic update_pulse;
		logic reset_pulse;
		logic last;
	} pin_action_t;

	pin_action_t expected_actions[$];
	logic [31:0] ref_clk_hz;
	int          errors = 0;
	int          depth  = 0;

	assign fail_count = errors;
	assign pending    = depth;

	// exact floor(f * 2^32 / ref), saturating; a zero divisor saturates too
	function automatic logic [31:0] tuning_word_of(input logic [31:0] f,
			input logic [31:0] refclk);
		logic [63:0] quot;
		if (refclk == 32'd0)
			return 32'hFFFF_FFFF;
		quot = {f, 32'd0} / {32'd0, refclk};
		if (quot[63:32] != 32'd0)
			return 32'hFFFF_FFFF;
		return quot[31:0];
	endfunction

	function automatic logic [7:0] swap_phase_bits(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		for (int i = 0; i < 5; i++)
			r[4-i] = c[i];
		return r;
	endfunction

	task automatic queue_action(input logic d, input logic wc, input logic up,
			input logic rs, input logic fin);
		expected_actions.push_back(pin_action_t'({d, wc, up, rs, fin}));
	endtask

	// tuning bits LSB first, control MSB first, closing update ends the run
	task automatic queue_frame(input logic [31:0] tw, input logic [7:0] cw);
		logic [7:0] c;
		c = swap_phase_bits(cw);
		for (int i = 0; i < 32; i++)
			queue_action(tw[i], 1'b1, 1'b0, 1'b0, 1'b0);
		for (int i = 0; i < 8; i++)
			queue_action(c[7-i], 1'b1, 1'b0, 1'b0, 1'b0);
		queue_action(1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
	endtask

	task automatic predict_request(input logic [1:0] op_raw, input logic [31:0] f,
			input logic [7:0] cw);
		case (dtsl_pkg::opcode_t'(op_raw))
			dtsl_pkg::OP_SETF: begin
				queue_frame(tuning_word_of(f, ref_clk_hz), cw);
			end
			dtsl_pkg::OP_PWDN: begin
				queue_action(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
				queue_action(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
				queue_frame(32'd0, dtsl_pkg::PD_CONTROL);
			end
			dtsl_pkg::OP_INIT: begin
				queue_action(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
				queue_action(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
				queue_action(1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
			end
			default: ; // undefined opcode: request is dropped
		endcase
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pin_action_t want;
		if (!arst_n) begin
			expected_actions.delete();
			ref_clk_hz = dtsl_pkg::REF_CLK_RESET;
			depth = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_actions.size() == 0) begin
					$display({"%0t: unexpected action, expected none actual ",
						"d=%0b wc=%0b up=%0b rs=%0b last=%0b"},
						$time, data_bit, word_clock_pulse, update_pulse,
						reset_pulse, last);
					errors++;
				end else begin
					want = expected_actions.pop_front();
					check_field("data_bit", want.data_bit, data_bit);
					check_field("word_clock_pulse", want.word_clock_pulse, word_clock_pulse);
					check_field("update_pulse", want.update_pulse, update_pulse);
					check_field("reset_pulse", want.reset_pulse, reset_pulse);
					check_field("last", want.last, last);
				end
			end
			if (cfg_wr_en)
				ref_clk_hz = cfg_wr_data;
			if (in_valid && !in_stall)
				predict_request(opcode, frequency_hz, control_word);
			depth = expected_actions.size();
		end
	end

endmodule

FILE: verif/dds_tuning_word_serial_loader_core_tb.sv
// ----------------------------------------------------------------------------
// dds_tuning_word_serial_loader_core_tb
// Drives set-frequency, power-down, init and undefined requests through the
// loader under several reference clock settings, with bursty requests and
// a randomly stalling action sink; the checker scores every pin action.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_tuning_word_serial_loader_core_tb;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int DRAIN_CYCLES    = 60;
	localparam int LONG_HOLD       = 400;
	localparam int ITEMS_PER_PHASE = 60;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [31:0] frequency_hz;
	logic [7:0]  control_word;
	logic        out_valid;
	logic        out_stall;
	logic        data_bit;
	logic        word_clock_pulse;
	logic        update_pulse;
	logic        reset_pulse;
	logic        last;
	int          fail_count;
	int          pending;

	logic [31:0] cur_ref;
	int          burst_left;
	bit          hold_req  = 1'b0;
	bit          hold_done = 1'b0;

	dds_tuning_word_serial_loader_core u_dut (.*);

	dtsl_action_checker u_checker (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// request pacing: bursts of random length, random gaps, some long bursts
	task automatic pace_sender();
		if (burst_left == 0) begin
			int gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid     = 1'b0;
				opcode       = $urandom_range(0, 3);
				frequency_hz = $urandom;
				control_word = $urandom_range(0, 255);
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_request(input dtsl_pkg::opcode_t op, input logic [31:0] f,
			input logic [7:0] cw);
		pace_sender();
		@(negedge clk);
		in_valid     = 1'b1;
		opcode       = op;
		frequency_hz = f;
		control_word = cw;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		// undefined requests leave nothing to wait on; give the divider time
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_ref_clock(input logic [31:0] v);
		wait_idle();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		cur_ref     = v;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		cfg_wr_data = $urandom;
	endtask

	function automatic logic [31:0] pick_frequency();
		case ($urandom_range(0, 6))
			0, 1: return $urandom;
			2: return (cur_ref == 32'd0) ? $urandom : $urandom_range(0, cur_ref - 32'd1);
			3: return cur_ref;
			4: return cur_ref - 32'd1;
			5: return ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd0;
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	task automatic run_random_phase(input int n, input bit long_hold, input bit mid_drain);
		int                 done;
		int                 r;
		dtsl_pkg::opcode_t  op;
		done = 0;
		while (done < n) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				op = dtsl_pkg::OP_SETF;
			else if (r < 75)
				op = dtsl_pkg::OP_PWDN;
			else if (r < 90)
				op = dtsl_pkg::OP_INIT;
			else
				op = dtsl_pkg::OP_NONE;
			if (op != dtsl_pkg::OP_NONE)
				done++;
			if (long_hold && done == 5)
				hold_req = 1'b1;
			if (mid_drain && done == n / 2 && op != dtsl_pkg::OP_NONE) begin
				@(negedge clk);
				in_valid = 1'b0;
				while (pending != 0) @(negedge clk);
			end
			send_request(op, pick_frequency(), $urandom_range(0, 255));
		end
	endtask

	// action sink: stall pattern switches between random modes
	initial begin
		int mode;
		int left;
		out_stall = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 150);
			end
			left--;
			case (mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 3) == 0);
				2: out_stall = ($urandom_range(0, 3) < 2);
				default: out_stall = ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = 32'd0;
		in_valid     = 1'b0;
		opcode       = dtsl_pkg::OP_SETF;
		frequency_hz = 32'd0;
		control_word = 8'd0;
		cur_ref      = dtsl_pkg::REF_CLK_RESET;
		burst_left   = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reference clock at its reset value
		send_request(dtsl_pkg::OP_INIT, 32'd0, 8'd0);
		send_request(dtsl_pkg::OP_PWDN, 32'hFFFF_FFFF, 8'hFF);
		send_request(dtsl_pkg::OP_SETF, 32'd0, 8'h00);
		send_request(dtsl_pkg::OP_SETF, 32'hFFFF_FFFF, 8'hFF);
		send_request(dtsl_pkg::OP_SETF, 32'd124_999_999, 8'h1F);
		send_request(dtsl_pkg::OP_SETF, 32'd125_000_000, 8'hE0);
		send_request(dtsl_pkg::OP_SETF, 32'd1, 8'h01);
		send_request(dtsl_pkg::OP_SETF, 32'd62_500_000, 8'h10);
		send_request(dtsl_pkg::OP_NONE, 32'h1234_5678, 8'h5A);
		send_request(dtsl_pkg::OP_SETF, 32'd30_000_000, 8'h15);
		send_request(dtsl_pkg::OP_INIT, 32'd0, 8'd0);

		// zero reference clock saturates the tuning word
		write_ref_clock(32'd0);
		send_request(dtsl_pkg::OP_SETF, 32'd0, 8'h00);
		send_request(dtsl_pkg::OP_SETF, 32'd12_345, 8'hAA);

		write_ref_clock(32'd1);
		send_request(dtsl_pkg::OP_SETF, 32'd0, 8'h0A);
		send_request(dtsl_pkg::OP_SETF, 32'd1, 8'h55);

		write_ref_clock(32'hFFFF_FFFF);
		send_request(dtsl_pkg::OP_SETF, 32'hFFFF_FFFF, 8'h3C);
		send_request(dtsl_pkg::OP_SETF, 32'hFFFF_FFFE, 8'hC3);
		send_request(dtsl_pkg::OP_SETF, 32'd1, 8'h80);
		send_request(dtsl_pkg::OP_PWDN, 32'd0, 8'd0);

		write_ref_clock(dtsl_pkg::REF_CLK_RESET);
		run_random_phase(ITEMS_PER_PHASE, 1'b1, 1'b0);
		write_ref_clock($urandom);
		run_random_phase(ITEMS_PER_PHASE, 1'b0, 1'b1);
		write_ref_clock($urandom_range(1, 1000));
		run_random_phase(ITEMS_PER_PHASE, 1'b0, 1'b0);
		write_ref_clock(32'hFFFF_FFFF);
		run_random_phase(ITEMS_PER_PHASE, 1'b0, 1'b0);
		write_ref_clock($urandom_range(1_000_000, 500_000_000));
		run_random_phase(ITEMS_PER_PHASE, 1'b0, 1'b0);
		write_ref_clock(32'd1);
		run_random_phase(ITEMS_PER_PHASE, 1'b0, 1'b0);

		wait_idle();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
src/dtsl_pkg.sv
src/dtsl_front.sv
src/dtsl_queue.sv
src/dtsl_back.sv
src/dds_tuning_word_serial_loader_core.sv
verif/dtsl_action_checker.sv
verif/dds_tuning_word_serial_loader_core_tb.sv
